### design/rcfb_pkg.sv
`default_nettype none

package rcfb_pkg;

   // Field codes
   localparam logic [1:0] KIND_METER = 2'd0;
   localparam logic [1:0] KIND_RELAY = 2'd1;
   localparam logic [1:0] STATE_OFF  = 2'd0;
   localparam logic [1:0] STATE_ON   = 2'd1;

   typedef enum logic [2:0] {
      ERR_NONE   = 3'd0,
      ERR_KIND   = 3'd1,
      ERR_STATE  = 3'd2,
      ERR_ADDR   = 3'd3,
      ERR_TARGET = 3'd4
   } err_type;

   // CSR indexes
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_FIRST     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAGIC_SECOND    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_VERSION   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DATA_FRAME_TYPE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SENDER_ROLE     = 3'd4;

   // Frame layout
   localparam logic [4:0] HDR_LEN     = 5'd13;
   localparam logic [4:0] METER_TOTAL = 5'd24;
   localparam logic [4:0] RELAY_TOTAL = 5'd21;
   localparam logic [7:0] METER_PLEN  = 8'd11;
   localparam logic [7:0] RELAY_PLEN  = 8'd8;

   // Modbus RTU constants
   localparam logic [7:0]  FC_WRITE_REGS = 8'h10;
   localparam logic [7:0]  FC_WRITE_COIL = 8'h05;
   localparam logic [7:0]  REG_ADDR_LO   = 8'h10;
   localparam logic [7:0]  REG_COUNT     = 8'h01;
   localparam logic [7:0]  BYTE_COUNT    = 8'h02;
   localparam logic [15:0] METER_OFF_VAL = 16'hAAAA;
   localparam logic [15:0] METER_ON_VAL  = 16'h5555;
   localparam logic [15:0] COIL_OFF_VAL  = 16'h0000;
   localparam logic [15:0] COIL_ON_VAL   = 16'hFF00;
   localparam logic [15:0] CRC_INIT      = 16'hFFFF;
   localparam logic [15:0] CRC_POLY      = 16'hA001;

   typedef struct packed {
      logic [1:0]  device_kind;
      logic [7:0]  bus_address;
      logic [7:0]  station_number;
      logic [15:0] target_node;
      logic [1:0]  switch_state;
      logic [7:0]  coil_channel;
      logic [15:0] sequence_number;
      logic [15:0] root_node;
   } req_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        last;
      logic [2:0]  error_code;
      logic [15:0] root_out;
      logic [15:0] target_out;
   } rsp_type;

   // Classified command handed from front to back
   typedef struct packed {
      err_type     err;
      logic        relay;
      logic        on;
      logic [7:0]  addr;
      logic [7:0]  chan;
      logic [15:0] target;
      logic [15:0] seq;
      logic [15:0] root;
   } desc_type;

   typedef struct packed {
      logic [7:0] magic_first;
      logic [7:0] magic_second;
      logic [7:0] frame_version;
      logic [7:0] data_frame_type;
      logic [7:0] sender_role;
   } hdr_cfg_type;

   // One byte of CRC-16/MODBUS, reflected
   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

### design/relay_command_frame_builder.sv
// Relay command frame builder.
// req_ channel: one switch command word per push, taken when req_push is
//   high and req_full is low. Commands are checked on entry and parked in
//   a short queue, so a new one can be pushed while a frame is still going out.
// rsp_ channel: one frame byte per word, oldest on rsp_data while rsp_empty
//   is low, taken on rsp_pop. A good command gives 24 words (meter) or 21
//   (relay), last set on the final one; a rejected command gives one word
//   carrying the error code.
// csr_ channel: header bytes, index 0..4, always ready; other indexes ignored.
//   Write only while the block is idle.
// Path: a command passes the queue, the back-end command register and the
//   output register before its first word shows. Throughput: one output word per
//   cycle while rsp_pop is high and commands wait, set by the back-end byte
//   sequencer and the byte-wide output register. CRC-16 is folded in one byte per cycle as the payload goes out.
// Reset: queue and output register empty, header registers zero.
// Stall: when rsp_pop stays low the sequencer holds; the queue fills and
//   req_full rises once QUEUE_DEPTH commands wait.
`default_nettype none

module relay_command_frame_builder
   import rcfb_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  req_type              req_data,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]           csr_data
);

   hdr_cfg_type hdr_ff, hdr_in;
   desc_type    front_desc;
   desc_type    q_data;
   logic        q_valid;
   logic        q_pop;

   assign csr_ready = 1'b1;

   // header register file
   always_comb begin
      hdr_in = hdr_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_MAGIC_FIRST:     hdr_in.magic_first     = csr_data;
            CSR_MAGIC_SECOND:    hdr_in.magic_second    = csr_data;
            CSR_FRAME_VERSION:   hdr_in.frame_version   = csr_data;
            CSR_DATA_FRAME_TYPE: hdr_in.data_frame_type = csr_data;
            CSR_SENDER_ROLE:     hdr_in.sender_role     = csr_data;
            default:             hdr_in = hdr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff <= '0;
      end else begin
         hdr_ff <= hdr_in;
      end
   end

   // front: classify
   rcfb_front u_front (
      .req  (req_data),
      .desc (front_desc)
   );

   // decoupling queue
   rcfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_desc),
      .full      (req_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_data  (q_data)
   );

   // back: byte sequencer, CRC, output register
   rcfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .hdr       (hdr_ff),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

### design/rcfb_front.sv
`default_nettype none

module rcfb_front
   import rcfb_pkg::*;
(
   input  req_type  req,
   output desc_type desc
);

   logic [7:0] addr;

   assign addr = (req.bus_address != 8'd0) ? req.bus_address : req.station_number;

   always_comb begin
      desc.relay  = (req.device_kind == KIND_RELAY);
      desc.on     = (req.switch_state == STATE_ON);
      desc.addr   = addr;
      desc.chan   = req.coil_channel;
      desc.target = req.target_node;
      desc.seq    = req.sequence_number;
      desc.root   = req.root_node;
      // check order: kind, state, address, target
      priority if (req.device_kind != KIND_METER && req.device_kind != KIND_RELAY) begin
         desc.err = ERR_KIND;
      end else if (req.switch_state != STATE_OFF && req.switch_state != STATE_ON) begin
         desc.err = ERR_STATE;
      end else if (addr == 8'd0) begin
         desc.err = ERR_ADDR;
      end else if (req.target_node == 16'd0) begin
         desc.err = ERR_TARGET;
      end else begin
         desc.err = ERR_NONE;
      end
   end

endmodule

`default_nettype wire

### design/rcfb_queue.sv
`default_nettype none

module rcfb_queue
   import rcfb_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  desc_type push_data,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output desc_type pop_data
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   desc_type           mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

### design/rcfb_back.sv
`default_nettype none

module rcfb_back
   import rcfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  hdr_cfg_type hdr,
   input  logic        q_valid,
   input  desc_type    q_data,
   output logic        q_pop,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output rsp_type     rsp_data
);

   logic        busy_ff, busy_in;
   desc_type    desc_ff, desc_in;
   logic [4:0]  idx_ff, idx_in;
   logic [15:0] crc_ff, crc_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;

   logic        adv;
   logic        is_last;
   logic        crc_upd;
   logic [7:0]  cur_byte;
   logic [7:0]  meter_val;
   logic [7:0]  coil_hi;

   assign adv       = busy_ff && (!rsp_valid_ff || rsp_pop);
   assign q_pop     = q_valid && (!busy_ff || (adv && is_last));
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign meter_val = desc_ff.on ? METER_ON_VAL[7:0] : METER_OFF_VAL[7:0];
   assign coil_hi   = desc_ff.on ? COIL_ON_VAL[15:8] : COIL_OFF_VAL[15:8];

   assign is_last = (desc_ff.err != ERR_NONE) ||
                    (idx_ff == (desc_ff.relay ? RELAY_TOTAL : METER_TOTAL) - 5'd1);

   // byte at current position; crc_upd marks RTU data bytes
   always_comb begin
      cur_byte = 8'h00;
      crc_upd  = 1'b0;
      unique case (idx_ff)
         5'd0:  cur_byte = hdr.magic_first;
         5'd1:  cur_byte = hdr.magic_second;
         5'd2:  cur_byte = hdr.frame_version;
         5'd3:  cur_byte = hdr.data_frame_type;
         5'd4:  cur_byte = hdr.sender_role;
         5'd7:  cur_byte = desc_ff.target[7:0];
         5'd8:  cur_byte = desc_ff.target[15:8];
         5'd9:  cur_byte = desc_ff.seq[7:0];
         5'd10: cur_byte = desc_ff.seq[15:8];
         5'd11: cur_byte = desc_ff.relay ? RELAY_PLEN : METER_PLEN;
         HDR_LEN: begin
            cur_byte = desc_ff.addr;
            crc_upd  = 1'b1;
         end
         default: begin
            if (desc_ff.relay) begin
               unique case (idx_ff)
                  5'd14: begin cur_byte = FC_WRITE_COIL; crc_upd = 1'b1; end
                  5'd15: begin cur_byte = 8'h00;         crc_upd = 1'b1; end
                  5'd16: begin cur_byte = desc_ff.chan;  crc_upd = 1'b1; end
                  5'd17: begin cur_byte = coil_hi;       crc_upd = 1'b1; end
                  5'd18: begin cur_byte = 8'h00;         crc_upd = 1'b1; end
                  5'd19: cur_byte = crc_ff[7:0];
                  5'd20: cur_byte = crc_ff[15:8];
                  default: cur_byte = 8'h00;
               endcase
            end else begin
               unique case (idx_ff)
                  5'd14: begin cur_byte = FC_WRITE_REGS; crc_upd = 1'b1; end
                  5'd15: begin cur_byte = 8'h00;         crc_upd = 1'b1; end
                  5'd16: begin cur_byte = REG_ADDR_LO;   crc_upd = 1'b1; end
                  5'd17: begin cur_byte = 8'h00;         crc_upd = 1'b1; end
                  5'd18: begin cur_byte = REG_COUNT;     crc_upd = 1'b1; end
                  5'd19: begin cur_byte = BYTE_COUNT;    crc_upd = 1'b1; end
                  5'd20: begin cur_byte = meter_val;     crc_upd = 1'b1; end
                  5'd21: begin cur_byte = meter_val;     crc_upd = 1'b1; end
                  5'd22: cur_byte = crc_ff[7:0];
                  5'd23: cur_byte = crc_ff[15:8];
                  default: cur_byte = 8'h00;
               endcase
            end
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      desc_in      = desc_ff;
      idx_in       = idx_ff;
      crc_in       = crc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (adv) begin
         rsp_valid_in = 1'b1;
         if (desc_ff.err != ERR_NONE) begin
            rsp_in.out_byte   = 8'h00;
            rsp_in.target_out = 16'd0;
         end else begin
            rsp_in.out_byte   = cur_byte;
            rsp_in.target_out = desc_ff.target;
         end
         rsp_in.last       = is_last;
         rsp_in.error_code = desc_ff.err;
         rsp_in.root_out   = desc_ff.root;
         idx_in            = idx_ff + 5'd1;
         if (crc_upd) begin
            crc_in = crc_byte(crc_ff, cur_byte);
         end
         if (is_last) begin
            busy_in = 1'b0;
         end
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end

      if (q_pop) begin
         busy_in = 1'b1;
         desc_in = q_data;
         idx_in  = 5'd0;
         crc_in  = CRC_INIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      idx_ff  <= idx_in;
      crc_ff  <= crc_in;
      rsp_ff  <= rsp_in;
   end

endmodule

`default_nettype wire

### design/rcfb_checker.sv
`default_nettype none

module rcfb_checker
   import rcfb_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_full,
   input logic    rsp_empty,
   input logic    rsp_pop,
   input rsp_type rsp_data
);

   // waiting word holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // error word is a lone, blank, final word
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_data.error_code != ERR_NONE |->
         rsp_data.last && rsp_data.out_byte == 8'h00 && rsp_data.target_out == 16'd0)
      else $error("malformed error word");

   a_err_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.error_code <= ERR_TARGET)
      else $error("error code out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("not empty after reset");

endmodule

bind relay_command_frame_builder rcfb_checker u_rcfb_checker (.*);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import rcfb_pkg::*;

   // Field codes the block rejects
   localparam logic [1:0] KIND_UNSUPPORTED = 2'd2;
   localparam logic [1:0] KIND_SPARE       = 2'd3;
   localparam logic [1:0] STATE_BAD_TWO    = 2'd2;
   localparam logic [1:0] STATE_BAD_THREE  = 2'd3;

   // Register indexes with no register behind them
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_LOW  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED_HIGH = 3'd7;

   localparam int RESET_CYCLES  = 12;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
   localparam int HOLD_AFTER    = 40;      // commands accepted before the hold-off
   localparam int CYCLE_LIMIT   = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   logic    req_full;
   req_type req_data = '0;
   logic    rsp_empty;
   logic    rsp_pop = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [7:0] csr_data = '0;

   // Commands waiting to be pushed, and frame words still owed by the block
   req_type pend_cmds[$];
   rsp_type frame_words_due[$];

   // Our copy of the header registers
   hdr_cfg_type hdr_shadow = '0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int accepted_cmds = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int hold_left = 0;
   logic rx_hold = 1'b0;
   logic hold_done = 1'b0;

   relay_command_frame_builder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #1 clock = ~clock;

   // Expected frame for one command: either one error word, or the 13-byte
   // header followed by the Modbus RTU payload and its CRC, one byte per word.
   function automatic void predict_frame(input req_type cmd);
      logic [7:0]  frame [0:23];
      logic [7:0]  addr;
      logic [15:0] val;
      logic [15:0] crc;
      int          plen;
      err_type     code;
      rsp_type     w;
      addr = (cmd.bus_address != 8'd0) ? cmd.bus_address : cmd.station_number;
      // checks in priority order: kind, state, address, target
      if (cmd.device_kind > KIND_RELAY)
         code = ERR_KIND;
      else if (cmd.switch_state > STATE_ON)
         code = ERR_STATE;
      else if (addr == 8'd0)
         code = ERR_ADDR;
      else if (cmd.target_node == 16'd0)
         code = ERR_TARGET;
      else
         code = ERR_NONE;
      if (code != ERR_NONE) begin
         w.out_byte   = 8'd0;
         w.last       = 1'b1;
         w.error_code = code;
         w.root_out   = cmd.root_node;
         w.target_out = 16'd0;
         frame_words_due.insert(frame_words_due.size(), w);
      end else begin
         frame[13] = addr;
         if (cmd.device_kind == KIND_METER) begin
            // write multiple registers, one register at 0x0010
            val = (cmd.switch_state == STATE_OFF) ? METER_OFF_VAL : METER_ON_VAL;
            frame[14] = FC_WRITE_REGS;
            frame[15] = 8'h00;
            frame[16] = REG_ADDR_LO;
            frame[17] = 8'h00;
            frame[18] = REG_COUNT;
            frame[19] = BYTE_COUNT;
            frame[20] = val[15:8];
            frame[21] = val[7:0];
            plen = 9;
         end else begin
            // write single coil, coil address 0x00:channel
            val = (cmd.switch_state == STATE_OFF) ? COIL_OFF_VAL : COIL_ON_VAL;
            frame[14] = FC_WRITE_COIL;
            frame[15] = 8'h00;
            frame[16] = cmd.coil_channel;
            frame[17] = val[15:8];
            frame[18] = val[7:0];
            plen = 6;
         end
         // CRC-16/MODBUS, reflected, low byte goes out first
         crc = CRC_INIT;
         for (int i = 0; i < plen; i++) begin
            crc = crc ^ {8'h00, frame[13 + i]};
            for (int b = 0; b < 8; b++)
               crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
         end
         frame[13 + plen] = crc[7:0];
         frame[14 + plen] = crc[15:8];
         plen = plen + 2;
         frame[0]  = hdr_shadow.magic_first;
         frame[1]  = hdr_shadow.magic_second;
         frame[2]  = hdr_shadow.frame_version;
         frame[3]  = hdr_shadow.data_frame_type;
         frame[4]  = hdr_shadow.sender_role;
         frame[5]  = 8'h00;                  // source id is always zero
         frame[6]  = 8'h00;
         frame[7]  = cmd.target_node[7:0];
         frame[8]  = cmd.target_node[15:8];
         frame[9]  = cmd.sequence_number[7:0];
         frame[10] = cmd.sequence_number[15:8];
         frame[11] = plen[7:0];
         frame[12] = 8'h00;
         for (int k = 0; k < 13 + plen; k++) begin
            w.out_byte   = frame[k];
            w.last       = (k == 12 + plen);
            w.error_code = ERR_NONE;
            w.root_out   = cmd.root_node;
            w.target_out = cmd.target_node;
            frame_words_due.insert(frame_words_due.size(), w);
         end
      end
   endfunction

   // Mostly well-formed commands; about one in five is noise that can hit
   // any of the rejection paths.
   function automatic req_type random_cmd();
      req_type c;
      c.coil_channel    = 8'($urandom_range(255));
      c.sequence_number = 16'($urandom_range(65535));
      c.root_node       = 16'($urandom_range(65535));
      if ($urandom_range(99) < 80) begin
         c.device_kind  = $urandom_range(1) ? KIND_RELAY : KIND_METER;
         c.switch_state = $urandom_range(1) ? STATE_ON : STATE_OFF;
         c.target_node  = 16'($urandom_range(1, 65535));
         if ($urandom_range(2) == 0) begin
            // station number fallback
            c.bus_address    = 8'd0;
            c.station_number = 8'($urandom_range(1, 255));
         end else begin
            c.bus_address    = 8'($urandom_range(1, 255));
            c.station_number = 8'($urandom_range(255));
         end
      end else begin
         c.device_kind    = 2'($urandom_range(3));
         c.switch_state   = 2'($urandom_range(3));
         c.bus_address    = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
         c.station_number = ($urandom_range(3) == 0) ? 8'd0 : 8'($urandom_range(255));
         c.target_node    = ($urandom_range(3) == 0) ? 16'd0 : 16'($urandom_range(65535));
      end
      return c;
   endfunction

   task automatic queue_cmd(input logic [1:0] kind, input logic [7:0] bus,
                            input logic [7:0] stn, input logic [15:0] target,
                            input logic [1:0] state, input logic [7:0] chan,
                            input logic [15:0] seq, input logic [15:0] root);
      req_type c;
      c.device_kind     = kind;
      c.bus_address     = bus;
      c.station_number  = stn;
      c.target_node     = target;
      c.switch_state    = state;
      c.coil_channel    = chan;
      c.sequence_number = seq;
      c.root_node       = root;
      pend_cmds.insert(pend_cmds.size(), c);
   endtask

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++)
         pend_cmds.insert(pend_cmds.size(), random_cmd());
   endtask

   // One register write; the shadow copy follows only mapped indexes.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MAGIC_FIRST:     hdr_shadow.magic_first = val;
         CSR_MAGIC_SECOND:    hdr_shadow.magic_second = val;
         CSR_FRAME_VERSION:   hdr_shadow.frame_version = val;
         CSR_DATA_FRAME_TYPE: hdr_shadow.data_frame_type = val;
         CSR_SENDER_ROLE:     hdr_shadow.sender_role = val;
         default: ;
      endcase
   endtask

   // All five header bytes, plus writes to unmapped indexes that must not land.
   task automatic set_header(input logic [7:0] first, input logic [7:0] second,
                             input logic [7:0] version, input logic [7:0] ftype,
                             input logic [7:0] role);
      write_csr(CSR_MAGIC_FIRST, first);
      write_csr(CSR_UNMAPPED_LOW, 8'($urandom_range(255)));
      write_csr(CSR_MAGIC_SECOND, second);
      write_csr(CSR_FRAME_VERSION, version);
      write_csr(CSR_DATA_FRAME_TYPE, ftype);
      write_csr(CSR_SENDER_ROLE, role);
      write_csr(CSR_UNMAPPED_HIGH, 8'($urandom_range(255)));
   endtask

   // Block is idle once nothing is queued, offered or owed; then let it settle.
   // Looked at on the falling edge, after the sender's updates have landed.
   task automatic wait_drained();
      do @(negedge clock);
      while (pend_cmds.size() != 0 || req_push || frame_words_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: holds a command until it is taken; between commands it may idle.
   always @(posedge clock) begin : drive_req
      logic offering;
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         offering = req_push;
         if (req_push && !req_full) begin
            predict_frame(req_data);
            accepted_cmds++;
            offering = 1'b0;
         end
         if (!offering) begin
            if (pend_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= pend_cmds.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks every taken word against the oldest owed word.
   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (frame_words_due.size() == 0) begin
               $display("%0t: unexpected word: byte=%02h last=%0b err=%0d root=%04h target=%04h",
                        $time, rsp_data.out_byte, rsp_data.last, rsp_data.error_code,
                        rsp_data.root_out, rsp_data.target_out);
               mismatch_count++;
            end else begin
               want = frame_words_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte || rsp_data.last !== want.last ||
                   rsp_data.error_code !== want.error_code ||
                   rsp_data.root_out !== want.root_out ||
                   rsp_data.target_out !== want.target_out) begin
                  $display("%0t: expected byte=%02h last=%0b err=%0d root=%04h target=%04h",
                           $time, want.out_byte, want.last, want.error_code,
                           want.root_out, want.target_out);
                  $display("%0t: actual   byte=%02h last=%0b err=%0d root=%04h target=%04h",
                           $time, rsp_data.out_byte, rsp_data.last, rsp_data.error_code,
                           rsp_data.root_out, rsp_data.target_out);
                  mismatch_count++;
               end
            end
         end
         rsp_pop <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // One long receiver hold-off, early in the first random phase, so the
   // command queue fills and req_full has to push back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         rx_hold   <= 1'b0;
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         if (hold_left == 1)
            rx_hold <= 1'b0;
      end else if (!hold_done && accepted_cmds >= HOLD_AFTER) begin
         rx_hold   <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d words still owed", $time, frame_words_due.size());
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed commands, header registers still at their reset value
      send_idle_pct = 22;
      recv_idle_pct = 85;
      queue_cmd(KIND_METER, 8'h01, 8'h00, 16'h0001, STATE_OFF, 8'h00, 16'h0000, 16'h0000);
      queue_cmd(KIND_METER, 8'hFF, 8'hFF, 16'hFFFF, STATE_ON, 8'hFF, 16'hFFFF, 16'hFFFF);
      queue_cmd(KIND_RELAY, 8'h11, 8'h00, 16'h1234, STATE_OFF, 8'h00, 16'h0001, 16'h8000);
      queue_cmd(KIND_RELAY, 8'h80, 8'h7F, 16'h8000, STATE_ON, 8'hFF, 16'h8000, 16'h0001);
      queue_cmd(KIND_RELAY, 8'hFF, 8'h00, 16'hFFFF, STATE_OFF, 8'hFF, 16'hFFFF, 16'hFFFF);
      // station number used when the bus address is unset
      queue_cmd(KIND_METER, 8'h00, 8'h5A, 16'h0102, STATE_ON, 8'h33, 16'h00FF, 16'h0F0F);
      queue_cmd(KIND_RELAY, 8'h00, 8'hFF, 16'h00FF, STATE_ON, 8'h5A, 16'hFF00, 16'hF0F0);
      queue_cmd(KIND_RELAY, 8'h00, 8'h01, 16'hFF00, STATE_OFF, 8'hA5, 16'h1234, 16'h5678);
      // unsupported kinds; kind wins over every later check
      queue_cmd(KIND_UNSUPPORTED, 8'h01, 8'h01, 16'h0001, STATE_OFF, 8'h00, 16'h0000, 16'hFFFF);
      queue_cmd(KIND_SPARE, 8'h22, 8'h00, 16'h4000, STATE_ON, 8'h01, 16'h0002, 16'h0000);
      queue_cmd(KIND_UNSUPPORTED, 8'h00, 8'h00, 16'h0000, STATE_BAD_THREE, 8'h00, 16'h0003,
                16'hABCD);
      // bad switch state; state wins over address and target
      queue_cmd(KIND_METER, 8'h10, 8'h00, 16'h0010, STATE_BAD_TWO, 8'h00, 16'h0004, 16'h1111);
      queue_cmd(KIND_RELAY, 8'h00, 8'h00, 16'h0000, STATE_BAD_THREE, 8'hFF, 16'h0005, 16'h2222);
      // no address at all; address wins over target
      queue_cmd(KIND_METER, 8'h00, 8'h00, 16'h0020, STATE_ON, 8'h00, 16'h0006, 16'h3333);
      queue_cmd(KIND_RELAY, 8'h00, 8'h00, 16'h0000, STATE_OFF, 8'h44, 16'h0007, 16'h4444);
      // missing target node
      queue_cmd(KIND_METER, 8'h01, 8'h00, 16'h0000, STATE_OFF, 8'h00, 16'h0008, 16'h5555);
      queue_cmd(KIND_RELAY, 8'h00, 8'h99, 16'h0000, STATE_ON, 8'h77, 16'h0009, 16'hFFFF);
      queue_cmd(KIND_RELAY, 8'h3C, 8'hC3, 16'h7FFF, STATE_ON, 8'h80, 16'h7FFF, 16'h7FFF);
      wait_drained();

      // All header bytes at the top, sender busy, receiver slow; the long
      // hold-off lands in here
      set_header(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
      queue_random(90);
      wait_drained();

      // Random header, sender slow, receiver busy
      set_header(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      send_idle_pct = 85;
      recv_idle_pct = 22;
      queue_random(90);
      wait_drained();

      // Mixed header with zeros, both sides at full rate
      set_header(8'h00, 8'hFF, 8'($urandom_range(255)), 8'h00, 8'($urandom_range(255)));
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(70);
      wait_drained();

      if (mismatch_count == 0 && frame_words_due.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
